// ----- rtl/core/pgg_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the pixel gain/gamma block.
// Used by the channel lane, the top level and the port checker; depends on nothing.
package pgg_pkg;

  localparam int unsigned IN_W       = 32;
  localparam int unsigned OUT_W      = 17;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned GAMMA_W    = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned LOG_BITS   = 28;

  // Register stages inside one channel lane, from multiply to rounded result.
  localparam int unsigned LANE_DEPTH = 61;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKDROP = 2'd3;

  typedef enum logic [2:0] {
    VIEW_RGB     = 3'd0,
    VIEW_RED     = 3'd1,
    VIEW_GREEN   = 3'd2,
    VIEW_BLUE    = 3'd3,
    VIEW_ALPHA   = 3'd4,
    VIEW_OVERLAY = 3'd5,
    VIEW_LUMA    = 3'd6
  } pgg_view_e;

  // Integer square root of a 64-bit value, evaluated at elaboration only.
  function automatic logic [63:0] pgg_isqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'd1 << 62;
    rem = n;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Factor 2^(-2^-idx) in Q0.32, built by repeated square roots.
  function automatic logic [31:0] pgg_exp_coef(int unsigned idx);
    logic [63:0] c;
    c = pgg_isqrt(64'd1 << 63);
    for (int unsigned i = 2; i <= LOG_BITS; i++) begin
      if (i <= idx) begin
        c = pgg_isqrt(c << 32);
      end
    end
    return c[31:0];
  endfunction

endpackage

// ----- rtl/core/pixel_gain_gamma_channel_view.sv -----
// Stages: 61 lane stages, then the output register that holds the view-selected result.
// Throughput: one pixel item per clock while the skid entry is free; all four channel lanes run in parallel.
// A two-entry output (register plus skid) lets the pipeline advance while a result waits.
// Reset is asynchronous, active low: valid bits clear and registers return to gain 1.0,
// inverse gamma 1.0, rgb view and no backdrop. Data registers are not reset.
module pixel_gain_gamma_channel_view #(
  parameter int unsigned FracBits = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pgg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pgg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pgg_pkg::IN_W-1:0]         red_in_i,
  input  logic [pgg_pkg::IN_W-1:0]         green_in_i,
  input  logic [pgg_pkg::IN_W-1:0]         blue_in_i,
  input  logic [pgg_pkg::IN_W-1:0]         alpha_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pgg_pkg::OUT_W-1:0]        red_out_o,
  output logic [pgg_pkg::OUT_W-1:0]        green_out_o,
  output logic [pgg_pkg::OUT_W-1:0]        blue_out_o,
  output logic [pgg_pkg::OUT_W-1:0]        alpha_out_o
);

  localparam int unsigned D   = pgg_pkg::LANE_DEPTH;
  localparam int unsigned TW  = FracBits + 1;
  localparam int unsigned GW  = pgg_pkg::GAIN_W;
  localparam int unsigned OW  = pgg_pkg::OUT_W;
  localparam logic [TW-1:0] ONE = TW'(1) << FracBits;
  localparam int unsigned NQ  = FracBits + 4;
  localparam int unsigned LPW = TW + 2 + NQ;
  localparam logic [LPW-1:0] THIRD = LPW'((2 ** NQ + 2) / 3);

  // Configuration registers.
  logic [GW-1:0]                 gain_q;
  logic [pgg_pkg::GAMMA_W-1:0]   gamma_q;
  pgg_pkg::pgg_view_e            view_q;
  logic                          backdrop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GW'(64'd1 << FracBits);
      gamma_q    <= pgg_pkg::GAMMA_W'(64'd1 << FracBits);
      view_q     <= pgg_pkg::VIEW_RGB;
      backdrop_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pgg_pkg::CFG_GAIN:     gain_q     <= cfg_wdata_i[GW-1:0];
        pgg_pkg::CFG_GAMMA:    gamma_q    <= cfg_wdata_i[pgg_pkg::GAMMA_W-1:0];
        pgg_pkg::CFG_VIEW:     view_q     <= pgg_pkg::pgg_view_e'(cfg_wdata_i[2:0]);
        pgg_pkg::CFG_BACKDROP: backdrop_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid entry is free.
  logic en;
  logic skid_vld_q;
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // Channel lanes; alpha runs at unity gain.
  logic [GW:0]   col_gain;
  logic [GW:0]   unit_gain;
  logic [TW-1:0] t_r, t_g, t_b, t_a;
  assign col_gain  = {1'b0, gain_q};
  assign unit_gain = (GW+1)'(64'd1 << FracBits);

  pgg_lane #(.FracBits(FracBits)) u_lane_r (
    .clk_i, .en_i(en), .sample_i(red_in_i), .gain_i(col_gain),
    .inv_gamma_i(gamma_q), .t_o(t_r)
  );
  pgg_lane #(.FracBits(FracBits)) u_lane_g (
    .clk_i, .en_i(en), .sample_i(green_in_i), .gain_i(col_gain),
    .inv_gamma_i(gamma_q), .t_o(t_g)
  );
  pgg_lane #(.FracBits(FracBits)) u_lane_b (
    .clk_i, .en_i(en), .sample_i(blue_in_i), .gain_i(col_gain),
    .inv_gamma_i(gamma_q), .t_o(t_b)
  );
  pgg_lane #(.FracBits(FracBits)) u_lane_a (
    .clk_i, .en_i(en), .sample_i(alpha_in_i), .gain_i(unit_gain),
    .inv_gamma_i(gamma_q), .t_o(t_a)
  );

  // Raw alpha saturated to 0..1, carried alongside the lanes.
  logic [TW-1:0] sat_in;
  logic [TW-1:0] sat_q [1:D];
  logic          vld_q [1:D];

  always_comb begin
    if (alpha_in_i[pgg_pkg::IN_W-1]) begin
      sat_in = '0;
    end else if (alpha_in_i > pgg_pkg::IN_W'(ONE)) begin
      sat_in = ONE;
    end else begin
      sat_in = alpha_in_i[TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q[1] <= sat_in;
      for (int s = 2; s <= D; s++) begin
        sat_q[s] <= sat_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= D; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int s = 2; s <= D; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // View selection, with luma as a reciprocal multiply for the divide by three.
  logic [TW+1:0]  lsum;
  logic [LPW-1:0] lprod;
  logic [TW-1:0]  luma;
  logic [TW:0]    osum;
  logic [TW-1:0]  v_r, v_g, v_b, v_a;

  always_comb begin
    lsum  = (TW+2)'(t_r) + (TW+2)'(t_g) + (TW+2)'(t_b) + (TW+2)'(1);
    lprod = LPW'(lsum) * THIRD;
    luma  = lprod[NQ+TW-1:NQ];
    osum  = (TW+1)'(t_a) + (TW+1)'(t_r) + (TW+1)'(1);
    v_r = t_r;
    v_g = t_g;
    v_b = t_b;
    v_a = t_a;
    case (view_q)
      pgg_pkg::VIEW_RED: begin
        v_g = t_r; v_b = t_r; v_a = sat_q[D];
      end
      pgg_pkg::VIEW_GREEN: begin
        v_r = t_g; v_b = t_g; v_a = sat_q[D];
      end
      pgg_pkg::VIEW_BLUE: begin
        v_r = t_b; v_g = t_b; v_a = sat_q[D];
      end
      pgg_pkg::VIEW_ALPHA: begin
        v_r = backdrop_q ? ONE : t_a;
        v_g = v_r;
        v_b = v_r;
      end
      pgg_pkg::VIEW_OVERLAY: begin
        v_r = osum[TW:1];
      end
      pgg_pkg::VIEW_LUMA: begin
        v_r = luma; v_g = luma; v_b = luma;
      end
      default: ;
    endcase
  end

  // Output register and skid entry.
  logic          out_vld_q;
  logic          out_vld_d, skid_vld_d;
  logic          load_out, load_skid, from_skid;
  logic [TW-1:0] o_r_q, o_g_q, o_b_q, o_a_q;
  logic [TW-1:0] s_r_q, s_g_q, s_b_q, s_a_q;

  always_comb begin
    load_out   = 1'b0;
    load_skid  = 1'b0;
    from_skid  = 1'b0;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (en) begin
      if (vld_q[D]) begin
        if (!out_vld_q || out_ready_i) begin
          load_out  = 1'b1;
          out_vld_d = 1'b1;
        end else begin
          load_skid  = 1'b1;
          skid_vld_d = 1'b1;
        end
      end else if (out_ready_i) begin
        out_vld_d = 1'b0;
      end
    end else if (out_ready_i) begin
      from_skid  = 1'b1;
      skid_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_r_q <= v_r; o_g_q <= v_g; o_b_q <= v_b; o_a_q <= v_a;
    end else if (from_skid) begin
      o_r_q <= s_r_q; o_g_q <= s_g_q; o_b_q <= s_b_q; o_a_q <= s_a_q;
    end
    if (load_skid) begin
      s_r_q <= v_r; s_g_q <= v_g; s_b_q <= v_b; s_a_q <= v_a;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = OW'(o_r_q);
  assign green_out_o = OW'(o_g_q);
  assign blue_out_o  = OW'(o_b_q);
  assign alpha_out_o = OW'(o_a_q);

endmodule

// ----- rtl/core/pgg_lane.sv -----
// One channel lane: gain multiply, log2 by repeated squaring, exponent multiply,
// 2^-x by a product of constant factors, then shift and rounding. Uses pgg_pkg.
module pgg_lane #(
  parameter int unsigned FracBits = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [pgg_pkg::IN_W-1:0]           sample_i,
  input  logic [pgg_pkg::GAIN_W:0]           gain_i,
  input  logic [pgg_pkg::GAMMA_W-1:0]        inv_gamma_i,
  output logic [FracBits:0]                  t_o
);

  localparam int unsigned LB    = pgg_pkg::LOG_BITS;
  localparam int unsigned PW    = pgg_pkg::IN_W + pgg_pkg::GAIN_W + 1;
  localparam int unsigned UW    = 2 * FracBits;
  localparam int unsigned KW    = $clog2(UW);
  localparam int unsigned LW    = $clog2(UW + 1) + LB;
  localparam int unsigned PRODW = LW + pgg_pkg::GAMMA_W;
  localparam int unsigned EW    = PRODW - FracBits;
  localparam int unsigned TW    = FracBits + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << FracBits;
  localparam logic [33:0] HALF  = 34'd1 << (31 - FracBits);
  localparam int unsigned LANE_END = pgg_pkg::LANE_DEPTH - 1;

  // Stage 1: gain product.
  logic signed [PW-1:0] p_q;

  // Carried per stage.
  logic          frc_q  [2:LANE_END];
  logic [TW-1:0] fval_q [2:LANE_END];
  logic [KW-1:0] kmsb_q [2:30];
  logic [31:0]   m_q    [2:30];
  logic [LB-1:0] frac_q [3:30];
  logic [LW-1:0] l_q;
  logic [EW-1:0] pe_q   [32:LANE_END];
  logic [32:0]   r_q    [33:LANE_END];
  logic [TW-1:0] t_q;

  // Stage 2: special cases and normalization to a Q1.31 mantissa.
  logic          neg_s2, big_s2;
  logic [UW-1:0] u_s2;
  logic [KW-1:0] kmsb_s2;
  logic [UW+31:0] ext_s2;
  logic [31:0]   m_s2;

  always_comb begin
    neg_s2  = p_q[PW-1] | (p_q == '0);
    big_s2  = |p_q[PW-2:UW];
    u_s2    = p_q[UW-1:0];
    kmsb_s2 = '0;
    for (int b = 0; b < UW; b++) begin
      if (u_s2[b]) begin
        kmsb_s2 = KW'(b);
      end
    end
    ext_s2 = {u_s2, 32'd0};
    m_s2   = 32'(ext_s2 >> ({1'b0, kmsb_s2} + (KW+1)'(1)));
  end

  // Log steps: square the mantissa, one fraction bit of log2 per stage.
  wire [31:0]   lm_d [LB];
  wire [LB-1:0] lf_d [LB];

  for (genvar j = 0; j < LB; j++) begin : g_log
    logic [63:0] sq;
    logic [LB-1:0] fin;
    assign sq  = 64'(m_q[2+j]) * 64'(m_q[2+j]);
    if (j == 0) begin : g_first
      assign fin = '0;
    end else begin : g_next
      assign fin = frac_q[2+j];
    end
    assign lm_d[j] = sq[63] ? sq[63:32] : sq[62:31];
    assign lf_d[j] = {fin[LB-2:0], sq[63]};
  end

  // Exponent product and its split into integer and fraction parts.
  logic [PRODW-1:0] prod_e;
  assign prod_e = PRODW'(l_q) * PRODW'(inv_gamma_i);

  // Exp steps: multiply by 2^(-2^-(LB-i)) where fraction bit i is set.
  wire [32:0] er_d [LB];

  for (genvar i = 0; i < LB; i++) begin : g_exp
    localparam logic [31:0] COEF = pgg_pkg::pgg_exp_coef(LB - i);
    logic [32:0] rin;
    logic [64:0] pr;
    if (i == 0) begin : g_first
      assign rin = 33'd1 << 32;
    end else begin : g_next
      assign rin = r_q[32+i];
    end
    assign pr      = 65'(rin) * 65'(COEF);
    assign er_d[i] = pe_q[32+i][i] ? pr[64:32] : rin;
  end

  // Final stage: integer shift, round half up, clamp to 1.0; forced values win, a shift of 40 or more gives 0.
  logic [EW-LB-1:0] ip_f;
  logic [32:0]      rs_f;
  logic [33:0]      sum_f;
  logic [TW:0]      rnd_f;
  logic [TW-1:0]    t_d;

  always_comb begin
    ip_f  = pe_q[LANE_END][EW-1:LB];
    rs_f  = r_q[LANE_END] >> ip_f;
    sum_f = 34'(rs_f) + HALF;
    rnd_f = sum_f[33:32-FracBits];
    if (frc_q[LANE_END]) begin
      t_d = fval_q[LANE_END];
    end else if (32'(ip_f) >= 32'd40) begin
      t_d = '0;
    end else if (rnd_f > (TW+1)'(ONE)) begin
      t_d = ONE;
    end else begin
      t_d = rnd_f[TW-1:0];
    end
  end

  // All lane stages move together under the shared enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= $signed(sample_i) * $signed(gain_i);

      frc_q[2]  <= neg_s2 | big_s2 | (inv_gamma_i == '0);
      fval_q[2] <= neg_s2 ? '0 : ONE;
      kmsb_q[2] <= kmsb_s2;
      m_q[2]    <= m_s2;
      for (int s = 3; s <= LANE_END; s++) begin
        frc_q[s]  <= frc_q[s-1];
        fval_q[s] <= fval_q[s-1];
      end
      for (int j = 0; j < LB; j++) begin
        kmsb_q[3+j] <= kmsb_q[2+j];
        m_q[3+j]    <= lm_d[j];
        frac_q[3+j] <= lf_d[j];
      end

      l_q <= LW'((LW'(UW) - LW'(kmsb_q[30])) << LB) - LW'(frac_q[30]);
      pe_q[32] <= prod_e[PRODW-1:FracBits];
      for (int i = 0; i < LB; i++) begin
        pe_q[33+i] <= pe_q[32+i];
        r_q[33+i]  <= er_d[i];
      end

      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

// ----- rtl/core/pgg_checker.sv -----
// Port-level checks for the pixel gain/gamma block, bound to its top level.
// Sees only the top-level ports; uses pgg_pkg for port widths.
module pgg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [pgg_pkg::OUT_W-1:0]        red_out_o,
  input logic [pgg_pkg::OUT_W-1:0]        alpha_out_o
);

  // Input stalls only while a result is held at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Stall begins only after an output item was refused.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stall without output back-pressure");

  // Draining the output frees the input in the next cycle.
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_ready_o |=> in_ready_o)
    else $error("input stayed stalled after output drain");

  // A refused result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(alpha_out_o))
    else $error("output item changed while stalled");

endmodule

bind pixel_gain_gamma_channel_view pgg_checker u_pgg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .alpha_out_o (alpha_out_o)
);

// ----- tb/sv/pixel_gain_gamma_channel_view_checker.sv -----
// Checker for the pixel gain/gamma block: watches the input and output handshakes and the register port,
// predicts every display pixel and compares it. Depends on pgg_pkg only.
module pixel_gain_gamma_channel_view_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pgg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pgg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [pgg_pkg::IN_W-1:0]       red_in_i,
  input  logic [pgg_pkg::IN_W-1:0]       green_in_i,
  input  logic [pgg_pkg::IN_W-1:0]       blue_in_i,
  input  logic [pgg_pkg::IN_W-1:0]       alpha_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [pgg_pkg::OUT_W-1:0]      red_out_i,
  input  logic [pgg_pkg::OUT_W-1:0]      green_out_i,
  input  logic [pgg_pkg::OUT_W-1:0]      blue_out_i,
  input  logic [pgg_pkg::OUT_W-1:0]      alpha_out_i,
  output int                             pending_o,
  output int                             errors_o
);

  localparam longint unsigned ONE = 64'd1 << 16;
  localparam int unsigned LB = pgg_pkg::LOG_BITS;

  typedef struct packed {
    logic [pgg_pkg::OUT_W-1:0] red;
    logic [pgg_pkg::OUT_W-1:0] green;
    logic [pgg_pkg::OUT_W-1:0] blue;
    logic [pgg_pkg::OUT_W-1:0] alpha;
  } pixel_t;

  logic [pgg_pkg::GAIN_W-1:0]  gain_q;
  logic [pgg_pkg::GAMMA_W-1:0] inv_gamma_q;
  logic [2:0]                  view_q;
  logic                        backdrop_q;
  pixel_t                      pixel_q[$];
  longint unsigned             root_coef[0:LB];
  int                          errors;

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n   = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Factors 2^(-2^-i) in Q0.32 by repeated square roots.
  initial begin
    root_coef[0] = 0;
    root_coef[1] = int_sqrt(64'd1 << 63);
    for (int i = 2; i <= LB; i++) root_coef[i] = int_sqrt(root_coef[i-1] << 32);
  end

  // One channel: gain, then power of inverse gamma through log2 and exp2, clamp to 0..1.
  function automatic longint unsigned gamma_lane(logic signed [31:0] s, longint unsigned k);
    longint          prod;
    longint unsigned u, m, frac, lg, pw, f, r;
    int              msb, ip;
    prod = longint'(s) * longint'(k);
    if (prod <= 0) return 0;
    if (prod >= (longint'(1) << 32)) return ONE;
    if (inv_gamma_q == 0) return ONE;
    u   = prod;
    msb = 0;
    while (msb < 63 && (u >> (msb + 1)) != 0) msb++;
    m = (msb <= 31) ? (u << (31 - msb)) : (u >> (msb - 31));
    frac = 0;
    for (int i = 0; i < LB; i++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if (m >= (64'd1 << 32)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    lg = (longint'(32 - msb) << LB) - frac;
    pw = (lg * longint'(inv_gamma_q)) >> 16;
    if ((pw >> LB) >= 40) return 0;
    ip = int'(pw >> LB);
    f  = pw & ((64'd1 << LB) - 1);
    r  = 64'd1 << 32;
    for (int i = 0; i < LB; i++)
      if (f[i]) r = (r * root_coef[LB - i]) >> 32;
    r = r >> ip;
    r = (r + (64'd1 << 15)) >> 16;
    if (r > ONE) r = ONE;
    return r;
  endfunction

  // Whole pixel under the current view setting.
  function automatic pixel_t predict_pixel(logic signed [31:0] rs, logic signed [31:0] gs,
                                           logic signed [31:0] bs, logic signed [31:0] as);
    longint unsigned r, g, b, a, k;
    pixel_t px;
    k = gain_q;
    r = gamma_lane(rs, k);
    g = gamma_lane(gs, k);
    b = gamma_lane(bs, k);
    a = gamma_lane(as, ONE);
    case (view_q)
      pgg_pkg::VIEW_RED, pgg_pkg::VIEW_GREEN, pgg_pkg::VIEW_BLUE: begin
        r = (view_q == pgg_pkg::VIEW_RED) ? r : ((view_q == pgg_pkg::VIEW_GREEN) ? g : b);
        g = r;
        b = r;
        a = (as < 0) ? 0 : ((as > 32'sd65536) ? ONE : longint'(as));
      end
      pgg_pkg::VIEW_ALPHA: begin
        r = backdrop_q ? ONE : a;
        g = r;
        b = r;
      end
      pgg_pkg::VIEW_OVERLAY: r = (a + r + 1) >> 1;
      pgg_pkg::VIEW_LUMA: begin
        r = (r + g + b + 1) / 3;
        g = r;
        b = r;
      end
      default: ;
    endcase
    px.red   = r[pgg_pkg::OUT_W-1:0];
    px.green = g[pgg_pkg::OUT_W-1:0];
    px.blue  = b[pgg_pkg::OUT_W-1:0];
    px.alpha = a[pgg_pkg::OUT_W-1:0];
    return px;
  endfunction

  // Register copy, following every write on the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= 24'd65536;
      inv_gamma_q <= 20'd65536;
      view_q      <= pgg_pkg::VIEW_RGB;
      backdrop_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pgg_pkg::CFG_GAIN:     gain_q      <= cfg_wdata_i[pgg_pkg::GAIN_W-1:0];
        pgg_pkg::CFG_GAMMA:    inv_gamma_q <= cfg_wdata_i[pgg_pkg::GAMMA_W-1:0];
        pgg_pkg::CFG_VIEW:     view_q      <= cfg_wdata_i[2:0];
        pgg_pkg::CFG_BACKDROP: backdrop_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Predict on each accepted input item, compare each accepted output item.
  initial errors = 0;
  always @(posedge clk_i) begin
    pixel_t want, got;
    if (rst_ni && in_valid_i && in_ready_i)
      pixel_q.push_back(predict_pixel(red_in_i, green_in_i, blue_in_i, alpha_in_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      got = {red_out_i, green_out_i, blue_out_i, alpha_out_i};
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output item %h", got);
      end else begin
        want = pixel_q.pop_front();
        if (want != got) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                     want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
        end
      end
    end
  end

  assign pending_o = pixel_q.size();
  assign errors_o  = errors;

endmodule

// ----- tb/sv/pixel_gain_gamma_channel_view_tb.sv -----
// Top of the pixel gain/gamma testbench: clock, reset, register phases and pixel stimulus.
// Depends on pgg_pkg, the block and pixel_gain_gamma_channel_view_checker.
module pixel_gain_gamma_channel_view_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 80;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [pgg_pkg::CFG_IDX_W-1:0]  cfg_idx_i = pgg_pkg::CFG_GAIN;
  logic [pgg_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [pgg_pkg::IN_W-1:0]       red_in_i = '0, green_in_i = '0, blue_in_i = '0,
                                  alpha_in_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [pgg_pkg::OUT_W-1:0]      red_out_o, green_out_o, blue_out_o, alpha_out_o;
  int                             pending, errors, cycles;
  bit                             calm = 1'b0;
  bit                             hold_req = 1'b0;

  pixel_gain_gamma_channel_view dut (.*);

  pixel_gain_gamma_channel_view_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .red_in_i, .green_in_i, .blue_in_i, .alpha_in_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .red_out_i(red_out_o), .green_out_i(green_out_o),
    .blue_out_i(blue_out_o), .alpha_out_i(alpha_out_o),
    .pending_o(pending), .errors_o(errors)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  always @(negedge clk_i) begin
    int stall, hold;
    if (hold_req && hold == 0 && stall >= 0) begin
      hold = 300;
    end
    if (hold > 0) begin
      hold--;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall > 0) begin
      stall--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
    if (hold_req && hold == 299) hold_req = 1'b0;
  end

  // Offer one pixel, with an optional idle burst first; returns after acceptance.
  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic [31:0] a);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    alpha_in_i <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register write; the write enable is dropped again before the task returns.
  task automatic write_reg(logic [pgg_pkg::CFG_IDX_W-1:0] idx,
                           logic [pgg_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Let the block empty out before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Sample biased toward the 0..1 range, with edges and full-width noise mixed in.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return -$urandom_range(0, 32'h2_0000);
      2:       return $urandom_range(0, 16);
      3:       return $urandom_range(32'hFFF0, 32'h1_0010);
      default: return $urandom_range(0, 32'h1_4000);
    endcase
  endfunction

  // Directed corner pixels.
  logic [31:0] corner_val[16] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h1_0000, 32'hFFFF, 32'h1_0001, 32'h1,
                                  32'h8000, 32'h4000, 32'h0000_0100, 32'h5555_5555,
                                  32'hAAAA_AAAA, 32'h0001_FFFF, 32'hFFFE_0000, 32'h2};

  initial begin
    logic [23:0] gain;
    logic [23:0] gam;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Defaults, plus values too wide for their registers (cut to width).
    write_reg(pgg_pkg::CFG_GAIN, 24'd65536);
    write_reg(pgg_pkg::CFG_GAMMA, 24'hF1_0000);
    write_reg(pgg_pkg::CFG_VIEW, 24'hFF_FFF8);
    write_reg(pgg_pkg::CFG_BACKDROP, 24'hFF_FFFE);
    for (int i = 0; i < 16; i++)
      send_pixel(corner_val[i], corner_val[15 - i], corner_val[(i + 5) % 16],
                 corner_val[(i + 9) % 16]);
    // Tiny product under a steep gamma gives a shift past the end.
    drain();
    write_reg(pgg_pkg::CFG_GAMMA, 24'hF_FFFF);
    send_pixel(32'h1, 32'h2, 32'h100, 32'h1);
    send_pixel(32'h8000, 32'hFFFF, 32'h1_0000, 32'h7FFF);

    // Register phases walking every view, gains and gammas from edge to edge.
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      case (ph % 4)
        0:       gain = 24'd65536;
        1:       gain = (ph == 1) ? 24'h0 : 24'hFF_FFFF;
        default: gain = 24'($urandom_range(24'h4000, 24'h4_0000));
      endcase
      case (ph % 5)
        0:       gam = 24'd65536;
        1:       gam = (ph == 1) ? 24'h0 : 24'hF_FFFF;
        2:       gam = 24'd29789;
        default: gam = 24'($urandom_range(1, 24'h4_0000));
      endcase
      write_reg(pgg_pkg::CFG_GAIN, gain);
      write_reg(pgg_pkg::CFG_GAMMA, gam);
      write_reg(pgg_pkg::CFG_VIEW, pgg_pkg::CFG_DATA_W'(ph % 8));
      write_reg(pgg_pkg::CFG_BACKDROP, pgg_pkg::CFG_DATA_W'((ph / 8) % 2));
      if (ph == 5) hold_req = 1'b1;
      if (ph == 15) calm = 1'b1;
      for (int n = 0; n < 110; n++)
        send_pixel(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pgg_pkg.sv
rtl/core/pgg_lane.sv
rtl/core/pixel_gain_gamma_channel_view.sv
rtl/core/pgg_checker.sv
tb/sv/pixel_gain_gamma_channel_view_checker.sv
tb/sv/pixel_gain_gamma_channel_view_tb.sv
